// File: rtl/core/jpd_pkg.sv
// ----------------------------------------------------------------------------
// jpd_pkg
// Shared types, register map and joint range ROM for the joint PD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package jpd_pkg;

   localparam int NUM_JOINTS = 12;

   // Register word index (paddr[4:2])
   typedef enum logic [2:0] {
      REG_CONTROL_MODE = 3'd0,
      REG_CMD_SCALE    = 3'd1,
      REG_PROP_GAIN    = 3'd2,
      REG_DERIV_GAIN   = 3'd3,
      REG_TORQUE_LIMIT = 3'd4
   } reg_addr_type;

   localparam logic MODE_TORQUE   = 1'b0;
   localparam logic MODE_POSITION = 1'b1;

   typedef struct packed {
      logic        control_mode;
      logic [15:0] cmd_scale;
      logic [15:0] prop_gain;
      logic [15:0] deriv_gain;
      logic [14:0] torque_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] lo;
      logic signed [15:0] hi;
   } limit_type;

   // Payload handed from the target stages to the torque stages
   typedef struct packed {
      logic [3:0]         joint;
      logic signed [15:0] target;
      logic               sat_pos;
      logic signed [16:0] err;
      logic signed [32:0] kdv;
   } target_stage_type;

   // Joint range ROM, Q4.12; joints without a row get the range [0,0]
   function automatic limit_type joint_limit(input logic [3:0] joint);
      limit_type r;
      r.lo = 16'sd0;
      r.hi = 16'sd0;
      if (int'(joint) < NUM_JOINTS) begin
         case (joint)
            4'd0, 4'd3, 4'd6, 4'd9: begin
               r.lo = -16'sd2048;
               r.hi = 16'sd2048;
            end
            4'd1, 4'd4, 4'd7, 4'd10: begin
               r.lo = 16'sd1638;
               r.hi = 16'sd5734;
            end
            4'd2, 4'd5: begin
               r.lo = -16'sd9421;
               r.hi = -16'sd3482;
            end
            4'd8, 4'd11: begin
               r.lo = -16'sd9421;
               r.hi = -16'sd5325;
            end
            default: begin
               r.lo = 16'sd0;
               r.hi = 16'sd0;
            end
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/jpd_req_if.sv
// ----------------------------------------------------------------------------
// jpd_req_if
// Input channel: one joint sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface jpd_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         joint;
   logic signed [15:0] action;
   logic signed [15:0] joint_pos;
   logic signed [15:0] joint_vel;

   modport source (output valid, joint, action, joint_pos, joint_vel, input ready);
   modport sink   (input valid, joint, action, joint_pos, joint_vel, output ready);
endinterface

`default_nettype wire

// File: rtl/core/jpd_rsp_if.sv
// ----------------------------------------------------------------------------
// jpd_rsp_if
// Result channel: one drive value per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface jpd_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         joint_out;
   logic signed [15:0] drive_value;
   logic               saturated;

   modport source (output valid, joint_out, drive_value, saturated, input ready);
   modport sink   (input valid, joint_out, drive_value, saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/core/jpd_csr.sv
// ----------------------------------------------------------------------------
// jpd_csr
// APB-style register file for mode, action scale, gains and torque limit.
// ----------------------------------------------------------------------------
`default_nettype none

module jpd_csr import jpd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type      cfg_ff;
   logic         wr_en;
   reg_addr_type addr;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign addr   = reg_addr_type'(paddr[4:2]);
   assign cfg    = cfg_ff;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_mode <= MODE_TORQUE;
         cfg_ff.cmd_scale    <= 16'd4096;
         cfg_ff.prop_gain    <= 16'd7680;
         cfg_ff.deriv_gain   <= 16'd0;
         cfg_ff.torque_limit <= 15'd12800;
      end else if (wr_en) begin
         case (addr)
            REG_CONTROL_MODE: cfg_ff.control_mode <= pwdata[0];
            REG_CMD_SCALE:    cfg_ff.cmd_scale    <= pwdata[15:0];
            REG_PROP_GAIN:    cfg_ff.prop_gain    <= pwdata[15:0];
            REG_DERIV_GAIN:   cfg_ff.deriv_gain   <= pwdata[15:0];
            REG_TORQUE_LIMIT: cfg_ff.torque_limit <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (addr)
         REG_CONTROL_MODE: prdata = {31'd0, cfg_ff.control_mode};
         REG_CMD_SCALE:    prdata = {16'd0, cfg_ff.cmd_scale};
         REG_PROP_GAIN:    prdata = {16'd0, cfg_ff.prop_gain};
         REG_DERIV_GAIN:   prdata = {16'd0, cfg_ff.deriv_gain};
         REG_TORQUE_LIMIT: prdata = {17'd0, cfg_ff.torque_limit};
         default:          prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/jpd_target.sv
// ----------------------------------------------------------------------------
// jpd_target
// Stages 1-3: range lookup, action scaling, range mapping, clamp, error.
// ----------------------------------------------------------------------------
`default_nettype none

module jpd_target import jpd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   jpd_req_if.sink       req,
   output logic          dn_valid,
   input  wire logic     dn_ready,
   output target_stage_type dn_data
);

   localparam logic signed [33:0] HALF_Q26  = 34'sd67108864;
   localparam logic signed [51:0] HALF_SPAN = 52'sd67108864;

   // Stage valids and per-stage ready
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy;

   // Stage 1 registers
   logic [3:0]         s1_joint_ff;
   logic signed [32:0] s1_prod_ff;
   logic signed [15:0] s1_lo_ff;
   logic signed [16:0] s1_diff_ff;
   logic signed [15:0] s1_pos_ff;
   logic signed [15:0] s1_vel_ff;

   // Stage 2 registers
   logic [3:0]         s2_joint_ff;
   logic signed [50:0] s2_span_ff;
   logic signed [15:0] s2_lo_ff;
   logic signed [15:0] s2_hi_ff;
   logic signed [15:0] s2_pos_ff;
   logic signed [32:0] s2_kdv_ff;

   target_stage_type   s3_ff;

   // Next values
   limit_type          lim_in;
   logic signed [32:0] prod_in;
   logic signed [16:0] diff_in;
   logic signed [33:0] base;
   logic signed [50:0] span_in;
   logic signed [32:0] kdv_in;
   logic signed [51:0] span_rnd;
   logic signed [24:0] span_q;
   logic signed [25:0] target_raw;
   target_stage_type   s3_in;
   logic signed [15:0] s1_hi_ff;

   assign s3_rdy    = !s3_vld_ff || dn_ready;
   assign s2_rdy    = !s2_vld_ff || s3_rdy;
   assign s1_rdy    = !s1_vld_ff || s2_rdy;
   assign req.ready = s1_rdy;
   assign dn_valid  = s3_vld_ff;
   assign dn_data   = s3_ff;

   // Stage 1: look up range, scale action
   always_comb begin
      lim_in  = joint_limit(req.joint);
      prod_in = req.action * $signed({1'b0, cfg.cmd_scale});
      diff_in = lim_in.hi - lim_in.lo;
   end

   // Stage 2: map scaled action onto the span, damping product
   always_comb begin
      base    = {s1_prod_ff[32], s1_prod_ff} + HALF_Q26;
      span_in = base * s1_diff_ff;
      kdv_in  = s1_vel_ff * $signed({1'b0, cfg.deriv_gain});
   end

   // Stage 3: round, offset, clamp to range, position error
   always_comb begin
      span_rnd   = {s2_span_ff[50], s2_span_ff} + HALF_SPAN;
      span_q     = span_rnd[51:27];
      target_raw = s2_lo_ff + span_q;
      s3_in.joint   = s2_joint_ff;
      s3_in.kdv     = s2_kdv_ff;
      s3_in.sat_pos = 1'b0;
      s3_in.target  = target_raw[15:0];
      if (target_raw < s2_lo_ff) begin
         s3_in.target  = s2_lo_ff;
         s3_in.sat_pos = 1'b1;
      end else if (target_raw > s2_hi_ff) begin
         s3_in.target  = s2_hi_ff;
         s3_in.sat_pos = 1'b1;
      end
      s3_in.err = s3_in.target - s2_pos_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= req.valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_joint_ff <= req.joint;
         s1_prod_ff  <= prod_in;
         s1_lo_ff    <= lim_in.lo;
         s1_hi_ff    <= lim_in.hi;
         s1_diff_ff  <= diff_in;
         s1_pos_ff   <= req.joint_pos;
         s1_vel_ff   <= req.joint_vel;
      end
      if (s2_rdy) begin
         s2_joint_ff <= s1_joint_ff;
         s2_span_ff  <= span_in;
         s2_lo_ff    <= s1_lo_ff;
         s2_hi_ff    <= s1_hi_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_kdv_ff   <= kdv_in;
      end
      if (s3_rdy) begin
         s3_ff <= s3_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/jpd_torque.sv
// ----------------------------------------------------------------------------
// jpd_torque
// Stages 4-5: PD torque, rounding, torque clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jpd_torque import jpd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     up_valid,
   output logic          up_ready,
   input  wire target_stage_type up_data,
   jpd_rsp_if.source     rsp
);

   localparam logic signed [38:0] HALF_Q12 = 39'sd2048;

   logic s4_vld_ff, s5_vld_ff;
   logic s4_rdy, s5_rdy;

   // Stage 4 registers
   logic [3:0]         s4_joint_ff;
   logic signed [15:0] s4_target_ff;
   logic               s4_sat_pos_ff;
   logic signed [33:0] s4_kperr_ff;
   logic signed [32:0] s4_kdv_ff;

   // Output registers
   logic [3:0]         s5_joint_ff;
   logic signed [15:0] s5_drive_ff;
   logic               s5_sat_ff;

   logic signed [33:0] kperr_in;
   logic signed [36:0] kdv_x16;
   logic signed [37:0] t20;
   logic signed [38:0] t20_rnd;
   logic signed [26:0] t8;
   logic signed [26:0] lim_pos;
   logic signed [26:0] lim_neg;
   logic signed [15:0] drive_in;
   logic               sat_in;

   assign s5_rdy   = !s5_vld_ff || rsp.ready;
   assign s4_rdy   = !s4_vld_ff || s5_rdy;
   assign up_ready = s4_rdy;

   assign rsp.valid       = s5_vld_ff;
   assign rsp.joint_out   = s5_joint_ff;
   assign rsp.drive_value = s5_drive_ff;
   assign rsp.saturated   = s5_sat_ff;

   // Stage 4: proportional product
   assign kperr_in = up_data.err * $signed({1'b0, cfg.prop_gain});

   // Stage 5: combine, round to Q8.8, clamp, pick by mode
   always_comb begin
      kdv_x16  = {s4_kdv_ff, 4'b0000};
      t20      = s4_kperr_ff - kdv_x16;
      t20_rnd  = t20 + HALF_Q12;
      t8       = t20_rnd[38:12];
      lim_pos  = $signed({12'd0, cfg.torque_limit});
      lim_neg  = -lim_pos;
      drive_in = t8[15:0];
      sat_in   = 1'b0;
      if (t8 > lim_pos) begin
         drive_in = lim_pos[15:0];
         sat_in   = 1'b1;
      end else if (t8 < lim_neg) begin
         drive_in = lim_neg[15:0];
         sat_in   = 1'b1;
      end
      if (cfg.control_mode == MODE_POSITION) begin
         drive_in = s4_target_ff;
         sat_in   = s4_sat_pos_ff;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (s4_rdy) begin
            s4_vld_ff <= up_valid;
         end
         if (s5_rdy) begin
            s5_vld_ff <= s4_vld_ff;
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_joint_ff   <= up_data.joint;
         s4_target_ff  <= up_data.target;
         s4_sat_pos_ff <= up_data.sat_pos;
         s4_kperr_ff   <= kperr_in;
         s4_kdv_ff     <= up_data.kdv;
      end
      if (s5_rdy) begin
         s5_joint_ff <= s4_joint_ff;
         s5_drive_ff <= drive_in;
         s5_sat_ff   <= sat_in;
      end
   end

   // A saturated torque sits exactly on one of the limits
   a_sat_on_limit: assert property (@(posedge clock) disable iff (reset)
      (s5_vld_ff && cfg.control_mode == MODE_TORQUE && s5_sat_ff) |->
      (s5_drive_ff == $signed({1'b0, cfg.torque_limit}) ||
       s5_drive_ff == -$signed({1'b0, cfg.torque_limit})))
      else $error("saturated torque is not at the limit");

   // Torque output never leaves the limit band
   a_torque_in_band: assert property (@(posedge clock) disable iff (reset)
      (s5_vld_ff && cfg.control_mode == MODE_TORQUE) |->
      (s5_drive_ff <= $signed({1'b0, cfg.torque_limit}) &&
       s5_drive_ff >= -$signed({1'b0, cfg.torque_limit})))
      else $error("torque outside limit band");

   // A stage blocked by the output keeps its transaction
   a_stage4_hold: assert property (@(posedge clock) disable iff (reset)
      (s4_vld_ff && !s5_rdy) |=> (s4_vld_ff && $stable(s4_kperr_ff)))
      else $error("stage 4 lost a transaction under stall");

endmodule

`default_nettype wire

// File: rtl/core/joint_pd_torque_controller.sv
// ----------------------------------------------------------------------------
// joint_pd_torque_controller
// Per-joint action-to-target mapping with PD torque or position output.
// ----------------------------------------------------------------------------
// Accepts one joint sample per cycle while the consumer takes results and
// returns its result through five register stages, one for each of the
// three multiplies (action*scale, mapping onto the joint span with the
// damping product, kp*error) plus range rounding/clamp and the final torque
// round/clamp in the output register. Throughput is one transaction per clock
// with no bubbles while the consumer is ready; each stage holds only while its
// successor is full, so the output register decouples a stalled consumer.
// Registers sit on the APB port at byte addresses 0,4,8,12,16 and must be
// written only while no transaction is in flight.
`default_nettype none

module joint_pd_torque_controller import jpd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   jpd_req_if.sink          req_chan,
   jpd_rsp_if.source        rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type          cfg;
   logic             mid_valid;
   logic             mid_ready;
   target_stage_type mid_data;

   // Register file
   jpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Target mapping stages
   jpd_target u_target (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req_chan),
      .dn_valid (mid_valid),
      .dn_ready (mid_ready),
      .dn_data  (mid_data)
   );

   // Torque stages and output register
   jpd_torque u_torque (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (mid_valid),
      .up_ready (mid_ready),
      .up_data  (mid_data),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

// File: test/joint_pd_torque_controller_tb.sv
// ----------------------------------------------------------------------------
// joint_pd_torque_controller_tb
// Self-checking testbench for the joint PD torque / position controller.
// A short directed table covers range extremes, both output modes, joints
// with no range row, a zero torque limit and an unmapped register. Random
// joint samples then run under several register settings. Each result is checked
// against the table entry or an in-bench model of the action mapping and PD law,
// with random idle cycles on both channels outside the burst phase.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_pd_torque_controller_tb import jpd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     LATENCY         = 5;
   localparam int     IDLE_PERCENT    = 37;
   localparam int     NUM_PHASES      = 8;
   localparam int     PHASE_SAMPLES   = 160;
   localparam int     BURST_PHASE     = 4;
   localparam int     DIRECTED_ROWS   = 31;
   localparam longint CYCLE_LIMIT     = 200000;
   localparam longint ROUND_Q27       = 64'sd67108864;
   localparam longint ROUND_Q12       = 64'sd2048;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [3:0]         joint;
      logic signed [15:0] action;
      logic signed [15:0] joint_pos;
      logic signed [15:0] joint_vel;
   } joint_sample_type;

   typedef struct packed {
      logic [3:0]         joint;
      logic signed [15:0] drive;
      logic               sat;
   } drive_result_type;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [2:0]       reg_index;
      logic [31:0]      wdata;
      joint_sample_type smp;
      bit               typed;
      drive_result_type result;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   jpd_req_if req_chan ();
   jpd_rsp_if rsp_chan ();

   // Register mirror
   logic        cfg_mode;
   logic [15:0] cfg_scale;
   logic [15:0] cfg_kp;
   logic [15:0] cfg_kd;
   logic [14:0] cfg_limit;

   drive_result_type pending_drives[$];
   drive_result_type due;
   int               fail_count;
   longint           cycle_count;
   bit               burst_mode;
   dir_row_type      directed_rows [DIRECTED_ROWS];

   joint_pd_torque_controller u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Map the action onto the joint range, then apply the PD law or pass the target
   function automatic drive_result_type predict_drive(joint_sample_type s);
      drive_result_type r;
      longint lo, hi, prod, span, tgt, err, t20, t8, lim;
      logic sat;
      lo = 0;
      hi = 0;
      if (int'(s.joint) < NUM_JOINTS) begin
         case (s.joint % 3)
            0: begin
               lo = -2048;
               hi = 2048;
            end
            1: begin
               lo = 1638;
               hi = 5734;
            end
            default: begin
               lo = -9421;
               hi = (s.joint < 4'd6) ? -3482 : -5325;
            end
         endcase
      end
      prod = longint'(s.action) * longint'(cfg_scale);
      span = (prod + ROUND_Q27) * (hi - lo);
      tgt  = lo + ((span + ROUND_Q27) >>> 27);
      sat  = 1'b0;
      if (tgt < lo) begin
         tgt = lo;
         sat = 1'b1;
      end else if (tgt > hi) begin
         tgt = hi;
         sat = 1'b1;
      end
      if (cfg_mode == MODE_POSITION) begin
         r.drive = tgt[15:0];
      end else begin
         err = tgt - longint'(s.joint_pos);
         t20 = longint'(cfg_kp) * err - longint'(cfg_kd) * longint'(s.joint_vel) * 16;
         t8  = (t20 + ROUND_Q12) >>> 12;
         lim = longint'(cfg_limit);
         sat = 1'b0;
         if (t8 > lim) begin
            t8  = lim;
            sat = 1'b1;
         end else if (t8 < -lim) begin
            t8  = -lim;
            sat = 1'b1;
         end
         r.drive = t8[15:0];
      end
      r.joint = s.joint;
      r.sat   = sat;
      return r;
   endfunction

   function automatic dir_row_type csr_row(logic [2:0] idx, logic [31:0] value);
      dir_row_type row;
      row.kind      = ROW_WRITE;
      row.reg_index = idx;
      row.wdata     = value;
      row.smp       = '0;
      row.typed     = 1'b0;
      row.result    = '0;
      return row;
   endfunction

   function automatic dir_row_type sample_row(logic [3:0] j, int a, int p, int v);
      dir_row_type row;
      row.kind          = ROW_SAMPLE;
      row.reg_index     = '0;
      row.wdata         = '0;
      row.typed         = 1'b0;
      row.result        = '0;
      row.smp.joint     = j;
      row.smp.action    = a[15:0];
      row.smp.joint_pos = p[15:0];
      row.smp.joint_vel = v[15:0];
      return row;
   endfunction

   function automatic dir_row_type checked_row(logic [3:0] j, int a, int p, int v,
                                               int drive, bit sat);
      dir_row_type row;
      row              = sample_row(j, a, p, v);
      row.typed        = 1'b1;
      row.result.joint = j;
      row.result.drive = drive[15:0];
      row.result.sat   = sat;
      return row;
   endfunction

   // Present one sample, after random idle cycles outside burst mode, hold until accepted
   task automatic send_sample(joint_sample_type s, bit typed,
                              drive_result_type typed_result);
      @(negedge clock);
      while (!burst_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.joint     = s.joint;
      req_chan.action    = s.action;
      req_chan.joint_pos = s.joint_pos;
      req_chan.joint_vel = s.joint_vel;
      req_chan.valid     = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      pending_drives = {pending_drives, (typed ? typed_result : predict_drive(s))};
   endtask

   // Drain the pipeline, then write one register over the APB port
   task automatic write_register(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_CONTROL_MODE: cfg_mode  = value[0];
         REG_CMD_SCALE:    cfg_scale = value[15:0];
         REG_PROP_GAIN:    cfg_kp    = value[15:0];
         REG_DERIV_GAIN:   cfg_kd    = value[15:0];
         REG_TORQUE_LIMIT: cfg_limit = value[14:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Stall the response channel at random outside the burst phase
   always @(negedge clock) begin
      rsp_chan.ready = burst_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_drives.size() == 0) begin
            $error("unexpected result: joint_out %0d drive_value %0d saturated %0b",
                   rsp_chan.joint_out, rsp_chan.drive_value, rsp_chan.saturated);
            fail_count++;
         end else begin
            due = pending_drives.pop_front();
            if (rsp_chan.joint_out !== due.joint) begin
               $error("joint_out: expected %0d, got %0d", due.joint, rsp_chan.joint_out);
               fail_count++;
            end
            if (rsp_chan.drive_value !== due.drive) begin
               $error("drive_value: expected %0d, got %0d", due.drive,
                      rsp_chan.drive_value);
               fail_count++;
            end
            if (rsp_chan.saturated !== due.sat) begin
               $error("saturated: expected %0b, got %0b", due.sat, rsp_chan.saturated);
               fail_count++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      joint_sample_type s;
      drive_result_type none;
      int               a;
      int               sel;
      logic [31:0]      phase_cfg [5];

      fail_count         = 0;
      cycle_count        = 0;
      burst_mode         = 1'b0;
      none               = '0;
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_chan.valid     = 1'b0;
      req_chan.joint     = '0;
      req_chan.action    = '0;
      req_chan.joint_pos = '0;
      req_chan.joint_vel = '0;
      rsp_chan.ready     = 1'b0;
      cfg_mode           = MODE_TORQUE;
      cfg_scale          = 16'd4096;
      cfg_kp             = 16'd7680;
      cfg_kd             = 16'd0;
      cfg_limit          = 15'd12800;

      directed_rows = '{
         // reset settings: torque mode, kp 30, kd 0, limit 50
         checked_row(4'd0, 0, 0, 0, 0, 1'b0),
         checked_row(4'd12, 0, -32768, 0, 12800, 1'b1),
         checked_row(4'd15, 0, 32767, 0, -12800, 1'b1),
         sample_row(4'd5, 32767, 0, 32767),
         sample_row(4'd2, -32768, -32768, -32768),
         // pure damping at full gain
         csr_row(REG_DERIV_GAIN, 32'd65535),
         csr_row(REG_PROP_GAIN, 32'd0),
         checked_row(4'd3, 0, 0, 32767, -12800, 1'b1),
         checked_row(4'd3, 0, 0, -32768, 12800, 1'b1),
         // zero torque limit forces zero output
         csr_row(REG_TORQUE_LIMIT, 32'd0),
         checked_row(4'd0, 0, 0, 0, 0, 1'b0),
         checked_row(4'd0, 0, 0, 1, 0, 1'b1),
         csr_row(REG_TORQUE_LIMIT, 32'd32767),
         csr_row(REG_DERIV_GAIN, 32'd0),
         csr_row(REG_PROP_GAIN, 32'd65535),
         sample_row(4'd7, 100, -32768, 0),
         sample_row(4'd1, -20000, 32767, -1),
         // write beyond the register list is dropped
         csr_row(REG_UNMAPPED, 32'hFFFF_FFFF),
         // position mode: range ends and clamps
         csr_row(REG_CONTROL_MODE, 32'(MODE_POSITION)),
         checked_row(4'd0, 16384, 0, 0, 2048, 1'b0),
         checked_row(4'd1, 16384, 0, 0, 5734, 1'b0),
         checked_row(4'd11, 32767, 0, 0, -5325, 1'b1),
         checked_row(4'd8, -32768, 0, 0, -9421, 1'b1),
         checked_row(4'd13, 32767, 0, 0, 0, 1'b0),
         checked_row(4'd4, -16384, 0, 0, 1638, 1'b0),
         csr_row(REG_CMD_SCALE, 32'd65535),
         sample_row(4'd6, 1, 0, 0),
         sample_row(4'd9, -1, 0, 0),
         // zero scale lands on the range midpoint
         csr_row(REG_CMD_SCALE, 32'd0),
         checked_row(4'd10, 32767, 0, 0, 3686, 1'b0),
         csr_row(REG_CONTROL_MODE, 32'(MODE_TORQUE))
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            write_register(directed_rows[i].reg_index, directed_rows[i].wdata);
         end else begin
            send_sample(directed_rows[i].smp, directed_rows[i].typed,
                        directed_rows[i].result);
         end
      end

      // Random phases, each under its own register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: phase_cfg = '{32'(MODE_TORQUE), 32'd65535, 32'd65535, 32'd65535, 32'd32767};
            1: phase_cfg = '{32'(MODE_TORQUE), 32'd0, 32'd0, 32'd0, 32'd0};
            2: phase_cfg = '{32'(MODE_POSITION), 32'd65535, 32'd0, 32'd0, 32'd0};
            default: begin
               phase_cfg[0] = 32'(p[0]);
               phase_cfg[1] = p[1] ? $urandom_range(0, 65535) : $urandom_range(2048, 8192);
               phase_cfg[2] = $urandom_range(0, 65535);
               phase_cfg[3] = p[1] ? $urandom_range(0, 65535) : $urandom_range(0, 1024);
               phase_cfg[4] = $urandom_range(0, 32767);
            end
         endcase
         write_register(REG_CONTROL_MODE, phase_cfg[0]);
         write_register(REG_CMD_SCALE, phase_cfg[1]);
         write_register(REG_PROP_GAIN, phase_cfg[2]);
         write_register(REG_DERIV_GAIN, phase_cfg[3]);
         write_register(REG_TORQUE_LIMIT, phase_cfg[4]);
         burst_mode = (p == BURST_PHASE);

         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            s.joint = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 11));
            sel = $urandom_range(0, 3);
            case (sel)
               0: a = $urandom_range(0, 65535);
               3: a = ($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 64) - 32;
               default: a = int'($urandom_range(0, 32768)) - 16384;
            endcase
            s.action    = a[15:0];
            s.joint_pos = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                               : 16'(int'($urandom_range(0, 20000)) - 10000);
            s.joint_vel = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                               : 16'(int'($urandom_range(0, 2048)) - 1024);
            send_sample(s, 1'b0, none);
         end
         burst_mode = 1'b0;
      end

      // Drain and report
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
